// File: hw/rtl/plsc_pkg.sv
// Package with the shared types, constants and register codes of the lid slew controller.
`default_nettype none

package plsc_pkg;

  // Field widths.
  localparam int unsigned DIST_W      = 13;
  localparam int unsigned ANGLE_W     = 8;
  localparam int unsigned ECHO_W      = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned HOLD_W      = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Filter depth default.
  localparam int unsigned FILTER_DEPTH_DEF = 8;

  // Echo to distance conversion: (us * 281) >> 10 gives 1/16 cm.
  localparam int unsigned ECHO_SCALE   = 281;
  localparam int unsigned ECHO_SCALE_W = 9;
  localparam int unsigned ECHO_SHIFT   = 10;
  localparam int unsigned PROD_W       = ECHO_W + ECHO_SCALE_W;
  localparam int unsigned CONV_W       = PROD_W - ECHO_SHIFT;

  // Valid distance window, 2 cm to 400 cm in 1/16 cm.
  localparam int unsigned MIN_DIST = 32;
  localparam int unsigned MAX_DIST = 6400;

  // Register reset values.
  localparam logic [DIST_W-1:0]  ENTRY_RST  = DIST_W'(480);
  localparam logic [DIST_W-1:0]  EXIT_RST   = DIST_W'(640);
  localparam logic [HOLD_W-1:0]  HOLD_RST   = HOLD_W'(3000);
  localparam logic [ANGLE_W-1:0] OPEN_RST   = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0] CLOSED_RST = ANGLE_W'(0);

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY  = 3'd0,
    REG_EXIT   = 3'd1,
    REG_HOLD   = 3'd2,
    REG_OPEN   = 3'd3,
    REG_CLOSED = 3'd4
  } cfg_reg_e;

  // Item opcodes.
  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_STEP    = 1'b1
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_UPD,
    ST_DIV,
    ST_DECIDE,
    ST_STEP,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/plsc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module plsc_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/plsc_div.sv
// Bit-serial restoring divider that averages the running sum by the fill count.
`default_nettype none

module plsc_div #(
  parameter int unsigned SUM_W = 17,
  parameter int unsigned CNT_W = 4,
  parameter int unsigned QUO_W = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [QUO_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvsr_q, dvsr_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  // One quotient bit per cycle: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh   = {rem_q, quo_q[SUM_W-1]};
    fits     = (rem_sh >= {1'b0, dvsr_q});
    rem_diff = rem_sh - {1'b0, dvsr_q};
    busy_d   = busy_q;
    done_d   = 1'b0;
    steps_d  = steps_q;
    rem_d    = rem_q;
    dvsr_d   = dvsr_q;
    quo_d    = quo_q;
    if (start_i) begin
      busy_d  = 1'b1;
      steps_d = STEP_W'(SUM_W);
      rem_d   = '0;
      dvsr_d  = divisor_i;
      quo_d   = dividend_i;
    end else if (busy_q) begin
      rem_d   = fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_d   = {quo_q[SUM_W-2:0], fits};
      steps_d = steps_q - STEP_W'(1);
      if (steps_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      steps_q <= steps_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    quo_q  <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[QUO_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/proximity_lid_slew_controller_top.sv
// Top level of the proximity lid slew controller: sequencer, filter ring, presence and servo.
//
// Each beat on the input is either an echo measurement or a servo step tick, and it produces
// exactly one result beat. Items are handled one at a time. A step tick passes through the
// step and finish states to a valid result. A measurement whose sample is in range passes
// through the convert, update, divide, decide and finish states; the divide state waits for
// the bit-serial divider that produces the average from the SUM_W-bit sum, one quotient bit
// per cycle, where SUM_W is 13 plus the fill count width. A measurement that is rejected
// (timeout or outside 2 to 400 cm) leaves the filter untouched and skips the divide state.
// The sample ring sits in a synchronous RAM that is read and rewritten at the write slot;
// the entry read there is only used once the ring is full, so no clearing pass follows reset.
// The output register lets the next item be accepted while a result waits for the downstream
// side. Configuration writes are always taken and act at once, also on an item in progress.
`default_nettype none

module proximity_lid_slew_controller_top #(
  parameter int unsigned FILTER_DEPTH = plsc_pkg::FILTER_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input channel.
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              opcode_i,
  input  wire logic [plsc_pkg::ECHO_W-1:0]       echo_us_i,
  input  wire logic [plsc_pkg::TIME_W-1:0]       now_ms_i,
  // Result channel.
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [plsc_pkg::DIST_W-1:0]       raw_distance_o,
  output logic                                   raw_valid_o,
  output logic      [plsc_pkg::DIST_W-1:0]       filtered_distance_o,
  output logic                                   filtered_valid_o,
  output logic                                   present_o,
  output logic      [plsc_pkg::ANGLE_W-1:0]      goal_angle_o,
  output logic      [plsc_pkg::ANGLE_W-1:0]      servo_angle_o,
  output logic                                   angle_moved_o,
  // Configuration write channel.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [plsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [plsc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import plsc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(FILTER_DEPTH + 1);
  localparam int unsigned SUM_W  = DIST_W + CNT_W;
  localparam int unsigned SLOT_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

  // Sequencer.
  state_e state_q, state_d;

  // Configuration registers.
  logic [DIST_W-1:0]  entry_thr_q;
  logic [DIST_W-1:0]  exit_thr_q;
  logic [HOLD_W-1:0]  hold_ms_q;
  logic [ANGLE_W-1:0] open_deg_q;
  logic [ANGLE_W-1:0] closed_deg_q;

  // Captured item.
  logic               opcode_q;
  logic [ECHO_W-1:0]  echo_q;
  logic [TIME_W-1:0]  now_q;

  // Sample conversion.
  logic [PROD_W-1:0]  echo_prod;
  logic [CONV_W-1:0]  conv_dist;
  logic               conv_ok;
  logic [DIST_W-1:0]  raw_q;
  logic               raw_ok_q;

  // Filter state.
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [DIST_W-1:0]  avg_q;
  logic               ring_full;
  logic [DIST_W-1:0]  ring_rdata;

  // Presence and angles.
  logic               present_q, present_d;
  logic [TIME_W-1:0]  last_seen_q;
  logic [TIME_W-1:0]  since_seen;
  logic [ANGLE_W-1:0] target_q;
  logic [ANGLE_W-1:0] current_q;
  logic               moved_q;

  // Sequencer outputs.
  logic               in_accept;
  logic               ram_we;
  logic               div_start;
  logic               div_done;
  logic [DIST_W-1:0]  div_quot;
  logic               out_load;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_thr_q  <= ENTRY_RST;
      exit_thr_q   <= EXIT_RST;
      hold_ms_q    <= HOLD_RST;
      open_deg_q   <= OPEN_RST;
      closed_deg_q <= CLOSED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ENTRY:  entry_thr_q  <= cfg_data_i[DIST_W-1:0];
        REG_EXIT:   exit_thr_q   <= cfg_data_i[DIST_W-1:0];
        REG_HOLD:   hold_ms_q    <= cfg_data_i[HOLD_W-1:0];
        REG_OPEN:   open_deg_q   <= cfg_data_i[ANGLE_W-1:0];
        REG_CLOSED: closed_deg_q <= cfg_data_i[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_e'(opcode_i) == OP_STEP) ? ST_STEP : ST_CONV;
        end
      end
      ST_CONV:   state_d = ST_UPD;
      ST_UPD:    state_d = raw_ok_q ? ST_DIV : ST_DECIDE;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: state_d = ST_FIN;
      ST_STEP:   state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_o || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    ram_we     = (state_q == ST_UPD) && raw_ok_q;
    div_start  = (state_q == ST_UPD) && raw_ok_q;
    out_load   = (state_q == ST_FIN) && (!out_valid_o || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the accepted item.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q <= opcode_i;
      echo_q   <= echo_us_i;
      now_q    <= now_ms_i;
    end
  end

  // Echo width to 1/16 cm and the range check.
  always_comb begin
    echo_prod = PROD_W'(echo_q) * PROD_W'(ECHO_SCALE);
    conv_dist = echo_prod[PROD_W-1:ECHO_SHIFT];
    conv_ok   = (echo_q != '0) && (conv_dist >= CONV_W'(MIN_DIST))
                && (conv_dist <= CONV_W'(MAX_DIST));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CONV) begin
      raw_q    <= conv_ok ? conv_dist[DIST_W-1:0] : '0;
      raw_ok_q <= conv_ok;
    end
  end

  // Ring update: the oldest sample read at the write slot leaves the sum once the ring is full.
  always_comb begin
    ring_full = (fill_q == CNT_W'(FILTER_DEPTH));
    slot_d    = (slot_q == SLOT_W'(FILTER_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
    fill_d    = ring_full ? fill_q : fill_q + CNT_W'(1);
    sum_d     = sum_q - (ring_full ? SUM_W'(ring_rdata) : '0) + SUM_W'(raw_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
      avg_q  <= '0;
    end else begin
      if (ram_we) begin
        slot_q <= slot_d;
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end
      if (div_done) begin
        avg_q <= div_quot;
      end
    end
  end

  plsc_ram #(
    .WIDTH (DIST_W),
    .DEPTH (FILTER_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (raw_q),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  plsc_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W),
    .QUO_W (DIST_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (fill_d),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Hysteresis on the average; an empty filter keeps the flag.
  always_comb begin
    present_d  = present_q;
    since_seen = now_q - last_seen_q;
    if (fill_q != '0) begin
      if (!present_q && (avg_q <= entry_thr_q)) begin
        present_d = 1'b1;
      end else if (present_q && (avg_q > exit_thr_q)) begin
        present_d = 1'b0;
      end
    end
  end

  // Presence, hold timer, target and servo angle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= 1'b0;
      last_seen_q <= '0;
      target_q    <= CLOSED_RST;
      current_q   <= CLOSED_RST;
      moved_q     <= 1'b0;
    end else begin
      if (in_accept) begin
        moved_q <= 1'b0;
      end
      if (state_q == ST_DECIDE) begin
        present_q <= present_d;
        if (present_d) begin
          last_seen_q <= now_q;
          target_q    <= open_deg_q;
        end else if (since_seen >= TIME_W'(hold_ms_q)) begin
          target_q <= closed_deg_q;
        end
      end
      if (state_q == ST_STEP) begin
        if (current_q < target_q) begin
          current_q <= current_q + ANGLE_W'(1);
          moved_q   <= 1'b1;
        end else if (current_q > target_q) begin
          current_q <= current_q - ANGLE_W'(1);
          moved_q   <= 1'b1;
        end
      end
    end
  end

  // Output register: holds a result beat until the downstream side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      raw_distance_o      <= (op_e'(opcode_q) == OP_STEP) ? '0 : raw_q;
      raw_valid_o         <= (op_e'(opcode_q) == OP_MEASURE) && raw_ok_q;
      filtered_distance_o <= avg_q;
      filtered_valid_o    <= (fill_q != '0);
      present_o           <= present_q;
      goal_angle_o        <= target_q;
      servo_angle_o       <= current_q;
      angle_moved_o       <= moved_q;
    end
  end

  // The ring never holds more samples than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(FILTER_DEPTH))
    else $error("fill count exceeds the filter depth");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  // A result from a valid sample never reports servo motion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && raw_valid_o) |-> !angle_moved_o)
    else $error("measurement result reports servo motion");

  // An empty filter reports a zero average.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !filtered_valid_o) |-> (filtered_distance_o == '0))
    else $error("empty filter reports a nonzero average");

endmodule

`default_nettype wire
